/* hw/rtl/spm_pkg.sv */
`default_nettype none

package spm_pkg;

    localparam int MAX_ROWS   = 8;
    localparam int MAX_COLS   = 8;
    localparam int ELEM_WIDTH = 32;

    localparam int VAL_W = 32;
    localparam int ROW_W = 3;
    localparam int COL_W = 3;
    localparam int CFG_W = 4;
    localparam int BND_W = ROW_W + 2;
    localparam int AW    = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
    localparam int REM_W = $clog2(MAX_ROWS * MAX_COLS + 1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Spiral legs, and the sequencer phases that enter a leg (4 + leg).
    localparam logic [1:0] LEG_TOP    = 2'd0;
    localparam logic [1:0] LEG_RIGHT  = 2'd1;
    localparam logic [1:0] LEG_BOTTOM = 2'd2;
    localparam logic [1:0] LEG_LEFT   = 2'd3;

    localparam logic [2:0] PH_TOP      = 3'd0;
    localparam logic [2:0] PH_RIGHT    = 3'd1;
    localparam logic [2:0] PH_BOTTOM   = 3'd2;
    localparam logic [2:0] PH_LEFT     = 3'd3;
    localparam logic [2:0] PH_ENTER_T  = 3'd4;
    localparam logic [2:0] PH_ENTER_R  = 3'd5;
    localparam logic [2:0] PH_ENTER_B  = 3'd6;
    localparam logic [2:0] PH_ENTER_L  = 3'd7;

    typedef struct packed {
        logic                    cmd;
        logic [ROW_W-1:0]        row_in;
        logic [COL_W-1:0]        col_in;
        logic signed [VAL_W-1:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        logic [ROW_W-1:0]        row_out;
        logic [COL_W-1:0]        col_out;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic wr;      // store one element
        logic cfg;     // configuration beat
        logic prep;    // restart if the previous spiral finished
        logic rd;      // read element and record the result
        logic adv;     // one phase of the position sequencer
    } t_dp_cmd;

    typedef struct packed {
        logic adv_done;
        logic last;
    } t_dp_sts;

    function automatic int eff_cnt(logic [CFG_W-1:0] v, int maxv);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > maxv) n = maxv;
        return n;
    endfunction

    function automatic logic [AW-1:0] mem_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        return AW'(int'(r) * MAX_COLS + int'(c));
    endfunction

    function automatic logic [ELEM_WIDTH-1:0] to_elem(logic [VAL_W-1:0] v);
        logic [63:0] w;
        w = {32'b0, v};
        return w[ELEM_WIDTH-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] from_elem(logic [ELEM_WIDTH-1:0] e);
        logic [63:0] w;
        w = 64'(signed'(e));
        return w[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/spm_ctrl.sv */
`default_nettype none

module spm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire logic            i_cmd,
    input  wire logic            i_cfg_valid,
    input  wire spm_pkg::t_dp_sts i_sts,
    output spm_pkg::t_dp_cmd     o_cmd,
    output logic                 busy,
    output logic                 o_cfg_ready
);
    import spm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_ADV  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign accept      = start && !busy;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.cfg  = i_cfg_valid && o_cfg_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_STEP) begin
                        n_state = S_PREP;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = i_sts.last ? S_IDLE : S_ADV;
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                if (i_sts.adv_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/spm_datapath.sv */
`default_nettype none

module spm_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spm_pkg::t_dp_cmd  i_cmd,
    input  wire spm_pkg::t_in_item i_in,
    input  wire logic              i_cfg_index,
    input  wire logic [spm_pkg::CFG_W-1:0] i_cfg_data,
    output spm_pkg::t_dp_sts       o_sts,
    output logic                   o_res_strobe,
    output spm_pkg::t_out_item     o_out
);
    import spm_pkg::*;

    logic [ELEM_WIDTH-1:0] mem [MAX_ROWS*MAX_COLS];

    logic [CFG_W-1:0]        r_rows, n_rows, r_cols, n_cols;
    logic signed [BND_W-1:0] r_top, n_top, r_bot, n_bot;
    logic signed [BND_W-1:0] r_left, n_left, r_right, n_right;
    logic [ROW_W-1:0]        r_cur_row, n_cur_row;
    logic [COL_W-1:0]        r_cur_col, n_cur_col;
    logic [1:0]              r_leg, n_leg;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [2:0]              r_phase, n_phase;
    logic                    r_strobe;
    logic [ELEM_WIDTH-1:0]   r_rd_data;
    logic [ROW_W-1:0]        r_out_row;
    logic [COL_W-1:0]        r_out_col;
    logic                    r_out_last;

    logic signed [BND_W-1:0] rs_bot, rs_right, cur_r, cur_c;
    logic [REM_W-1:0]        rs_rem;
    logic                    is_last, adv_done, restart;
    int                      er, ec;

    assign er       = eff_cnt(n_rows, MAX_ROWS);
    assign ec       = eff_cnt(n_cols, MAX_COLS);
    assign rs_bot   = BND_W'(er - 1);
    assign rs_right = BND_W'(ec - 1);
    assign rs_rem   = REM_W'(er * ec);
    assign cur_r    = signed'(BND_W'(r_cur_row));
    assign cur_c    = signed'(BND_W'(r_cur_col));
    assign is_last  = (r_rem == REM_W'(1));

    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        if (i_cmd.cfg) begin
            if (i_cfg_index == REG_ROWS) begin
                n_rows = i_cfg_data;
            end else begin
                n_cols = i_cfg_data;
            end
        end
    end

    // Position sequencer: one phase per cycle. Entering an empty leg applies
    // that leg's bound update and moves on to the next leg's entry phase.
    always_comb begin
        n_top     = r_top;
        n_bot     = r_bot;
        n_left    = r_left;
        n_right   = r_right;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_leg     = r_leg;
        n_rem     = r_rem;
        n_phase   = r_phase;
        adv_done  = 1'b0;
        restart   = i_cmd.cfg || (i_cmd.prep && r_rem == '0) || (i_cmd.rd && is_last);
        if (restart) begin
            n_top     = '0;
            n_left    = '0;
            n_bot     = rs_bot;
            n_right   = rs_right;
            n_cur_row = '0;
            n_cur_col = '0;
            n_leg     = LEG_TOP;
            n_rem     = rs_rem;
        end else if (i_cmd.rd) begin
            n_rem   = r_rem - REM_W'(1);
            n_phase = {1'b0, r_leg};
        end else if (i_cmd.adv) begin
            case (r_phase)
                PH_TOP: begin
                    if (cur_c < r_right) begin
                        n_cur_col = r_cur_col + COL_W'(1);
                        adv_done  = 1'b1;
                    end else begin
                        n_top   = r_top + BND_W'(1);
                        n_phase = PH_ENTER_R;
                    end
                end
                PH_RIGHT: begin
                    if (cur_r < r_bot) begin
                        n_cur_row = r_cur_row + ROW_W'(1);
                        adv_done  = 1'b1;
                    end else begin
                        n_right = r_right - BND_W'(1);
                        n_phase = PH_ENTER_B;
                    end
                end
                PH_BOTTOM: begin
                    if (cur_c > r_left) begin
                        n_cur_col = r_cur_col - COL_W'(1);
                        adv_done  = 1'b1;
                    end else begin
                        n_bot   = r_bot - BND_W'(1);
                        n_phase = PH_ENTER_L;
                    end
                end
                PH_LEFT: begin
                    if (cur_r > r_top) begin
                        n_cur_row = r_cur_row - ROW_W'(1);
                        adv_done  = 1'b1;
                    end else begin
                        n_left  = r_left + BND_W'(1);
                        n_phase = PH_ENTER_T;
                    end
                end
                PH_ENTER_T: begin
                    adv_done = 1'b1;
                    if (r_top <= r_bot && r_left <= r_right) begin
                        n_cur_row = r_top[ROW_W-1:0];
                        n_cur_col = r_left[COL_W-1:0];
                        n_leg     = LEG_TOP;
                    end
                end
                PH_ENTER_R: begin
                    if (r_top <= r_bot) begin
                        n_cur_row = r_top[ROW_W-1:0];
                        n_cur_col = r_right[COL_W-1:0];
                        n_leg     = LEG_RIGHT;
                        adv_done  = 1'b1;
                    end else begin
                        n_right = r_right - BND_W'(1);
                        n_phase = PH_ENTER_B;
                    end
                end
                PH_ENTER_B: begin
                    n_phase = PH_ENTER_L;
                    if (r_top <= r_bot) begin
                        if (r_right >= r_left) begin
                            n_cur_row = r_bot[ROW_W-1:0];
                            n_cur_col = r_right[COL_W-1:0];
                            n_leg     = LEG_BOTTOM;
                            adv_done  = 1'b1;
                        end else begin
                            n_bot = r_bot - BND_W'(1);
                        end
                    end
                end
                default: begin
                    n_phase = PH_ENTER_T;
                    if (r_left <= r_right) begin
                        if (r_bot >= r_top) begin
                            n_cur_row = r_bot[ROW_W-1:0];
                            n_cur_col = r_left[COL_W-1:0];
                            n_leg     = LEG_LEFT;
                            adv_done  = 1'b1;
                        end else begin
                            n_left = r_left + BND_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && int'(i_in.row_in) < MAX_ROWS && int'(i_in.col_in) < MAX_COLS) begin
            mem[mem_addr(i_in.row_in, i_in.col_in)] <= to_elem(i_in.value_in);
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[mem_addr(r_cur_row, r_cur_col)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_out_row  <= r_cur_row;
            r_out_col  <= r_cur_col;
            r_out_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= CFG_W'(6);
            r_cols    <= CFG_W'(6);
            r_top     <= '0;
            r_left    <= '0;
            r_bot     <= BND_W'(5);
            r_right   <= BND_W'(5);
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_leg     <= LEG_TOP;
            r_rem     <= REM_W'(36);
            r_phase   <= PH_TOP;
            r_strobe  <= 1'b0;
        end else begin
            r_rows    <= n_rows;
            r_cols    <= n_cols;
            r_top     <= n_top;
            r_left    <= n_left;
            r_bot     <= n_bot;
            r_right   <= n_right;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_leg     <= n_leg;
            r_rem     <= n_rem;
            r_phase   <= n_phase;
            r_strobe  <= i_cmd.rd;
        end
    end

    assign o_sts.adv_done  = adv_done;
    assign o_sts.last      = is_last;
    assign o_res_strobe    = r_strobe;
    assign o_out.value_out = from_elem(r_rd_data);
    assign o_out.row_out   = r_out_row;
    assign o_out.col_out   = r_out_col;
    assign o_out.last      = r_out_last;

endmodule

`default_nettype wire

/* hw/rtl/spiral_matrix_reader.sv */
`default_nettype none

// Spiral matrix reader. A write command (cmd low) stores one element, and busy
// never rises for it. A step command (cmd high) keeps busy high while it checks
// for a finished spiral, reads the element RAM and, unless the element is the
// last of the spiral, runs the position sequencer, which settles one leg test or
// bound update per cycle. The result beat shows on o_res_strobe for exactly one
// cycle, from a register loaded during the RAM read; the receiver cannot stall
// it and must take it then. Configuration beats are taken whenever busy is low
// and restart the spiral at the top-left corner.
module spiral_matrix_reader (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire spm_pkg::t_in_item        i_in,
    output logic                          o_res_strobe,
    output spm_pkg::t_out_item            o_out,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic                     i_cfg_index,
    input  wire logic [spm_pkg::CFG_W-1:0] i_cfg_data
);
    import spm_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    spm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_in.cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .busy        (busy),
        .o_cfg_ready (o_cfg_ready)
    );

    spm_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_in         (i_in),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_sts        (dp_sts),
        .o_res_strobe (o_res_strobe),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

/* hw/rtl/spm_checker.sv */
`default_nettype none

module spm_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire spm_pkg::t_in_item         i_in,
    input wire logic                      o_res_strobe,
    input wire spm_pkg::t_out_item        o_out,
    input wire logic                      i_cfg_valid,
    input wire logic                      o_cfg_ready,
    input wire logic                      i_cfg_index,
    input wire logic [spm_pkg::CFG_W-1:0] i_cfg_data
);
    import spm_pkg::*;

    // Every accepted step yields its result beat on o_res_strobe.
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.cmd == CMD_STEP) |-> ##3 o_res_strobe)
        else $error("step beat without result three cycles later");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("result strobe held for more than one cycle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(busy))
        else $error("result beat without a step in progress");

    // A write finishes in the cycle it is accepted.
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.cmd == CMD_WRITE) |=> !busy)
        else $error("write beat left the block busy");

endmodule

bind spiral_matrix_reader spm_checker u_spm_checker (.*);

`default_nettype wire

/* sim/tb_spiral_matrix_reader.sv */
module tb_spiral_matrix_reader;
    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 200;
    localparam int MAX_PRINTS    = 40;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    t_in_item            i_in        = '0;
    logic                o_res_strobe;
    t_out_item           o_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data  = '0;

    spiral_matrix_reader uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_in         (i_in),
        .o_res_strobe (o_res_strobe),
        .o_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the block: element store, count registers and spiral position.
    logic signed [VAL_W-1:0] elem_store [MAX_ROWS*MAX_COLS];
    logic [CFG_W-1:0]        rows_reg;
    logic [CFG_W-1:0]        cols_reg;
    int                      sp_top, sp_bottom, sp_left, sp_right;
    int                      sp_row, sp_col, sp_todo;
    logic [1:0]              sp_leg;
    t_out_item               pending_elems [$];

    int items_sent  = 0;
    int error_count = 0;
    bit gaps_on     = 1'b1;

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int clamp_count(input logic [CFG_W-1:0] v, input int ceiling);
        if (v == '0)
            return 1;
        if (int'(v) > ceiling)
            return ceiling;
        return int'(v);
    endfunction

    function automatic void spiral_restart();
        sp_top    = 0;
        sp_left   = 0;
        sp_bottom = clamp_count(rows_reg, MAX_ROWS) - 1;
        sp_right  = clamp_count(cols_reg, MAX_COLS) - 1;
        sp_row    = 0;
        sp_col    = 0;
        sp_leg    = LEG_TOP;
        sp_todo   = (sp_bottom + 1) * (sp_right + 1);
    endfunction

    // Walks the sequencer phases until the next position is found. Entering an
    // empty leg applies that leg's bound update and falls through to the next.
    function automatic void spiral_advance();
        logic [2:0] ph;
        ph = {1'b0, sp_leg};
        repeat (16) begin
            case (ph)
                PH_TOP: begin
                    if (sp_col < sp_right) begin
                        sp_col++;
                        return;
                    end
                    sp_top++;
                    ph = PH_ENTER_R;
                end
                PH_RIGHT: begin
                    if (sp_row < sp_bottom) begin
                        sp_row++;
                        return;
                    end
                    sp_right--;
                    ph = PH_ENTER_B;
                end
                PH_BOTTOM: begin
                    if (sp_col > sp_left) begin
                        sp_col--;
                        return;
                    end
                    sp_bottom--;
                    ph = PH_ENTER_L;
                end
                PH_LEFT: begin
                    if (sp_row > sp_top) begin
                        sp_row--;
                        return;
                    end
                    sp_left++;
                    ph = PH_ENTER_T;
                end
                PH_ENTER_T: begin
                    if (sp_top <= sp_bottom && sp_left <= sp_right) begin
                        sp_row = sp_top;
                        sp_col = sp_left;
                        sp_leg = LEG_TOP;
                    end
                    return;
                end
                PH_ENTER_R: begin
                    if (sp_top <= sp_bottom) begin
                        sp_row = sp_top;
                        sp_col = sp_right;
                        sp_leg = LEG_RIGHT;
                        return;
                    end
                    sp_right--;
                    ph = PH_ENTER_B;
                end
                PH_ENTER_B: begin
                    if (sp_top <= sp_bottom) begin
                        if (sp_right >= sp_left) begin
                            sp_row = sp_bottom;
                            sp_col = sp_right;
                            sp_leg = LEG_BOTTOM;
                            return;
                        end
                        sp_bottom--;
                    end
                    ph = PH_ENTER_L;
                end
                default: begin
                    if (sp_left <= sp_right) begin
                        if (sp_bottom >= sp_top) begin
                            sp_row = sp_bottom;
                            sp_col = sp_left;
                            sp_leg = LEG_LEFT;
                            return;
                        end
                        sp_left++;
                    end
                    ph = PH_ENTER_T;
                end
            endcase
        end
    endfunction

    function automatic void predict_spiral_beat(input t_in_item item);
        t_out_item want;
        if (item.cmd == CMD_WRITE) begin
            elem_store[int'(item.row_in) * MAX_COLS + int'(item.col_in)] = item.value_in;
            return;
        end
        if (sp_todo == 0)
            spiral_restart();
        want.value_out = elem_store[sp_row * MAX_COLS + sp_col];
        want.row_out   = ROW_W'(sp_row);
        want.col_out   = COL_W'(sp_col);
        want.last      = (sp_todo == 1);
        pending_elems.push_back(want);
        if (want.last) begin
            spiral_restart();
        end else begin
            sp_todo--;
            spiral_advance();
        end
    endfunction

    // Samples at each rising edge: results first, since a result taken at the
    // same edge as a new step always belongs to an older step.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            rows_reg = 4'd6;
            cols_reg = 4'd6;
            spiral_restart();
        end else begin
            if (o_res_strobe) begin
                if (pending_elems.size() == 0) begin
                    report_mismatch($sformatf("element r%0d c%0d with none pending",
                                              o_out.row_out, o_out.col_out));
                end else begin
                    want = pending_elems.pop_front();
                    if (o_out.value_out !== want.value_out)
                        report_mismatch($sformatf("value_out %h, predicted %h",
                                                  o_out.value_out, want.value_out));
                    if (o_out.row_out !== want.row_out)
                        report_mismatch($sformatf("row_out %0d, predicted %0d",
                                                  o_out.row_out, want.row_out));
                    if (o_out.col_out !== want.col_out)
                        report_mismatch($sformatf("col_out %0d, predicted %0d",
                                                  o_out.col_out, want.col_out));
                    if (o_out.last !== want.last)
                        report_mismatch($sformatf("last %b, predicted %b",
                                                  o_out.last, want.last));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_ROWS)
                    rows_reg = i_cfg_data;
                else
                    cols_reg = i_cfg_data;
                spiral_restart();
            end
            if (start && !busy)
                predict_spiral_beat(i_in);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_res_strobe || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [VAL_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return '0;
        if (roll < 14)
            return CFG_W'($urandom_range(9, 15));
        return CFG_W'($urandom_range(1, 8));
    endfunction

    function automatic t_in_item make_item(input logic cmd, input logic [ROW_W-1:0] r,
                                           input logic [COL_W-1:0] c,
                                           input logic [VAL_W-1:0] v);
        t_in_item item;
        item.cmd      = cmd;
        item.row_in   = r;
        item.col_in   = c;
        item.value_in = v;
        return item;
    endfunction

    // Holds start high until the beat is taken. Called right after a rising edge.
    task automatic issue_cmd(input t_in_item item);
        if (gaps_on && $urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= item;
        @(negedge i_clk);
        while (busy)
            @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_elem(input int r, input int c, input logic [VAL_W-1:0] v);
        issue_cmd(make_item(CMD_WRITE, ROW_W'(r), COL_W'(c), v));
    endtask

    task automatic step_spiral(input int n);
        repeat (n)
            issue_cmd(make_item(CMD_STEP, ROW_W'($urandom_range(0, 7)),
                                COL_W'($urandom_range(0, 7)), $urandom));
    endtask

    // Register beats go in only once every pending element has come out and
    // the block has had time to finish its last position update.
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        start <= 1'b0;
        while (pending_elems.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready)
            @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Every element is written before the first step, so no read ever hits
    // an entry that was never written.
    task automatic test_fill_store();
        for (int r = 0; r < MAX_ROWS; r++)
            for (int c = 0; c < MAX_COLS; c++)
                write_elem(r, c, rand_word());
    endtask

    task automatic test_reset_spiral();
        step_spiral(6 * 6 + 3);
    endtask

    task automatic test_small_shapes();
        write_elem(0, 0, 32'h8000_0000);
        write_elem(0, 1, 32'h7fff_ffff);
        write_elem(1, 0, 32'h0000_0000);
        write_elem(1, 1, 32'hffff_ffff);
        write_elem(7, 7, 32'h5a5a_a5a5);
        // Zero counts act as one: a single element, flagged last every time.
        write_reg(REG_ROWS, 4'd0);
        write_reg(REG_COLS, 4'd0);
        step_spiral(2);
        // A register write in the middle of a spiral restarts it at the corner.
        write_reg(REG_ROWS, 4'd2);
        write_reg(REG_COLS, 4'd2);
        step_spiral(5);
        write_reg(REG_ROWS, 4'd1);
        step_spiral(3);
        write_reg(REG_ROWS, 4'd2);
        write_reg(REG_COLS, 4'd1);
        step_spiral(3);
    endtask

    task automatic test_largest_spiral();
        write_reg(REG_ROWS, 4'd15);
        write_reg(REG_COLS, 4'd8);
        step_spiral(MAX_ROWS * MAX_COLS + 2);
    endtask

    task automatic test_random_spirals(input int n_items, input bit with_gaps);
        int goal;
        int span;
        gaps_on = with_gaps;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_ROWS, pick_count());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_COLS, pick_count());
            span = $urandom_range(8, 140);
            repeat (span) begin
                if ($urandom_range(0, 99) < 20)
                    write_elem($urandom_range(0, 7), $urandom_range(0, 7), rand_word());
                else
                    step_spiral(1);
            end
        end
    endtask

    initial begin
        int waited;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_fill_store();
        test_reset_spiral();
        test_small_shapes();
        test_largest_spiral();
        test_random_spirals(800, 1'b1);
        test_random_spirals(800, 1'b0);
        start <= 1'b0;
        waited = 0;
        while (pending_elems.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_elems.size() != 0)
            report_mismatch($sformatf("%0d predicted elements never came out",
                                      pending_elems.size()));
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
